### sv/bmpa_pkg.sv
// ----------------------------------------------------------------------------
// bmpa_pkg
// Shared types, constants and tables for the beam mask power accumulator.
// ----------------------------------------------------------------------------
package bmpa_pkg;

   localparam int MAX_POINTS     = 65536;
   localparam int EXP_TABLE_BITS = 10;
   localparam int EDGE_CAP_INT   = (MAX_POINTS < 131071) ? MAX_POINTS : 131071;
   localparam logic [16:0] EDGE_CAP = 17'(EDGE_CAP_INT);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int NUM_SUMS  = 8;
   localparam int NUM_STATS = 9;

   localparam logic [17:0] E_MAX   = 18'h3FFFF;
   localparam logic [16:0] ONE_Q16 = 17'h10000;
   localparam logic [62:0] SUM_MAX = {63{1'b1}};

   localparam logic signed [31:0] LOG2_SCALE = 32'sd10885;
   localparam logic signed [31:0] EXP_BIAS   = 32'sd268435456;  // 16 << 24
   localparam logic signed [31:0] EXP_LIMIT  = 32'sd301989888;  // 18 << 24

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_AZ_NOMINAL   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EL_NOMINAL   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUB_RADIUS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_RADIUS   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SIZE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COPOL_PEAK   = 3'd5;

   localparam logic [3:0] STAT_LAST = 4'(NUM_STATS - 1);

   typedef enum logic [1:0] {
      EXP_NORM = 2'd0,
      EXP_ZERO = 2'd1,
      EXP_SAT  = 2'd2
   } exp_cls_type;

   typedef struct packed {
      logic [31:0]               ax;
      logic [31:0]               ay;
      exp_cls_type               cls;
      logic [4:0]                exp_int;
      logic [EXP_TABLE_BITS-1:0] exp_frac;
      logic                      eos;
   } entry_type;

   // rounded Q30 factors 2^(2^-(k+1))
   function automatic logic [30:0] pow2_frac(input logic [3:0] k);
      logic [30:0] v;
      unique case (k)
         4'd0:    v = 31'd1518500250;
         4'd1:    v = 31'd1276901417;
         4'd2:    v = 31'd1170923762;
         4'd3:    v = 31'd1121280438;
         4'd4:    v = 31'd1097253708;
         4'd5:    v = 31'd1085434106;
         4'd6:    v = 31'd1079572136;
         4'd7:    v = 31'd1076653033;
         4'd8:    v = 31'd1075196443;
         4'd9:    v = 31'd1074468888;
         4'd10:   v = 31'd1074105294;
         4'd11:   v = 31'd1073923544;
         4'd12:   v = 31'd1073832680;
         4'd13:   v = 31'd1073787251;
         default: v = 31'd1073741824;
      endcase
      return v;
   endfunction

endpackage

### sv/beam_mask_power_accumulator_core.sv
// ----------------------------------------------------------------------------
// beam_mask_power_accumulator_core
// Per-point field, radius and masks with running scan statistics.
// ----------------------------------------------------------------------------
//   channel  direction  handshake             payload
//   req_*    in         req_valid/req_stall   x, y angles, amp dB, end of scan
//   rsp_*    out        rsp_valid/rsp_stall   point or statistic result
//   csr_*    in         csr_we                index, 32-bit write data
//
// The back sequencer takes the queue head, runs the bit-serial square root
// (32 steps) and the taper divider (17 steps), and then loads the result
// register; an end-of-scan point adds nine statistic results.
// Synchronous active-high reset clears the sums, queue and sequencer.
// A stalled result holds in the output register; the two-entry queue keeps
// taking items until full.
module beam_mask_power_accumulator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [31:0]                  req_x_angle,
   input  logic signed [31:0]                  req_y_angle,
   input  logic signed [15:0]                  req_amp_db,
   input  logic                                req_end_of_scan,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_result_kind,
   output logic [17:0]                         rsp_e_field,
   output logic [31:0]                         rsp_radius,
   output logic [16:0]                         rsp_mask,
   output logic [16:0]                         rsp_reduced_mask,
   output logic [3:0]                          rsp_stat_index,
   output logic [62:0]                         rsp_stat_value,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [bmpa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                         csr_wdata
);
   import bmpa_pkg::*;

   logic signed [31:0] az_nominal_ff;
   logic signed [31:0] el_nominal_ff;
   logic        [31:0] sub_radius_ff;
   logic        [31:0] red_radius_ff;
   logic        [31:0] step_size_ff;
   logic signed [15:0] copol_peak_ff;

   entry_type front_entry;
   entry_type head_entry;
   logic      q_full;
   logic      q_not_empty;
   logic      q_push;
   logic      q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         az_nominal_ff <= '0;
         el_nominal_ff <= '0;
         sub_radius_ff <= '0;
         red_radius_ff <= '0;
         step_size_ff  <= 32'd65536;
         copol_peak_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_AZ_NOMINAL: az_nominal_ff <= csr_wdata;
            CSR_EL_NOMINAL: el_nominal_ff <= csr_wdata;
            CSR_SUB_RADIUS: sub_radius_ff <= csr_wdata;
            CSR_RED_RADIUS: red_radius_ff <= csr_wdata;
            CSR_STEP_SIZE:  step_size_ff  <= csr_wdata;
            CSR_COPOL_PEAK: copol_peak_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   bmpa_front u_front (
      .req_x_angle     (req_x_angle),
      .req_y_angle     (req_y_angle),
      .req_amp_db      (req_amp_db),
      .req_end_of_scan (req_end_of_scan),
      .az_nominal      (az_nominal_ff),
      .el_nominal      (el_nominal_ff),
      .copol_peak_amp  (copol_peak_ff),
      .entry           (front_entry)
   );

   bmpa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wr_entry  (front_entry),
      .pop       (q_pop),
      .rd_entry  (head_entry),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   bmpa_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_not_empty),
      .q_entry          (head_entry),
      .q_pop            (q_pop),
      .sub_radius       (sub_radius_ff),
      .red_radius       (red_radius_ff),
      .step_size        (step_size_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_e_field      (rsp_e_field),
      .rsp_radius       (rsp_radius),
      .rsp_mask         (rsp_mask),
      .rsp_reduced_mask (rsp_reduced_mask),
      .rsp_stat_index   (rsp_stat_index),
      .rsp_stat_value   (rsp_stat_value),
      .rsp_last         (rsp_last)
   );

endmodule

### sv/bmpa_front.sv
// ----------------------------------------------------------------------------
// bmpa_front
// Takes request items, forms pointing offsets and classifies the dB exponent.
// ----------------------------------------------------------------------------
module bmpa_front (
   input  logic                signed [31:0] req_x_angle,
   input  logic                signed [31:0] req_y_angle,
   input  logic                signed [15:0] req_amp_db,
   input  logic                              req_end_of_scan,
   input  logic                signed [31:0] az_nominal,
   input  logic                signed [31:0] el_nominal,
   input  logic                signed [15:0] copol_peak_amp,
   output bmpa_pkg::entry_type               entry
);
   import bmpa_pkg::*;

   logic signed [32:0] dx;
   logic signed [32:0] dy;
   logic        [32:0] ax;
   logic        [32:0] ay;
   logic signed [16:0] d;
   logic signed [31:0] u;

   always_comb begin
      dx = 33'(req_x_angle) - 33'(az_nominal);
      dy = 33'(req_y_angle) - 33'(el_nominal);
      ax = dx[32] ? 33'(-dx) : 33'(dx);
      ay = dy[32] ? 33'(-dy) : 33'(dy);
      d  = 17'(req_amp_db) - 17'(copol_peak_amp);
      u  = 32'(d) * LOG2_SCALE + EXP_BIAS;

      entry.ax       = ax[31:0];
      entry.ay       = ay[31:0];
      entry.exp_int  = u[28:24];
      entry.exp_frac = u[23:24-EXP_TABLE_BITS];
      entry.eos      = req_end_of_scan;
      if (u >= EXP_LIMIT) begin
         entry.cls = EXP_SAT;
      end else if (u < 0) begin
         entry.cls = EXP_ZERO;
      end else begin
         entry.cls = EXP_NORM;
      end
   end

endmodule

### sv/bmpa_queue.sv
// ----------------------------------------------------------------------------
// bmpa_queue
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
module bmpa_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bmpa_pkg::entry_type wr_entry,
   input  logic                pop,
   output bmpa_pkg::entry_type rd_entry,
   output logic                not_empty,
   output logic                full
);
   import bmpa_pkg::*;

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;

   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

   assign rd_entry  = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/bmpa_back.sv
// ----------------------------------------------------------------------------
// bmpa_back
// Sequencer for radius, field, masks and sums, with the result register.
// ----------------------------------------------------------------------------
module bmpa_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  bmpa_pkg::entry_type q_entry,
   output logic                q_pop,
   input  logic [31:0]         sub_radius,
   input  logic [31:0]         red_radius,
   input  logic [31:0]         step_size,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_result_kind,
   output logic [17:0]         rsp_e_field,
   output logic [31:0]         rsp_radius,
   output logic [16:0]         rsp_mask,
   output logic [16:0]         rsp_reduced_mask,
   output logic [3:0]          rsp_stat_index,
   output logic [62:0]         rsp_stat_value,
   output logic                rsp_last
);
   import bmpa_pkg::*;

   typedef enum logic [15:0] {
      ST_IDLE = 16'h0001,
      ST_SQX  = 16'h0002,
      ST_SQY  = 16'h0004,
      ST_ADD  = 16'h0008,
      ST_SQRT = 16'h0010,
      ST_EXP  = 16'h0020,
      ST_EFIN = 16'h0040,
      ST_TSET = 16'h0080,
      ST_DIV  = 16'h0100,
      ST_MSEL = 16'h0200,
      ST_MUL1 = 16'h0400,
      ST_MUL2 = 16'h0800,
      ST_MUL3 = 16'h1000,
      ST_ACC  = 16'h2000,
      ST_EMPT = 16'h4000,
      ST_STAT = 16'h8000
   } state_type;

   typedef enum logic [1:0] {
      TP_ZERO = 2'd0,
      TP_ONE  = 2'd1,
      TP_DIV  = 2'd2
   } taper_cls_type;

   typedef struct packed {
      taper_cls_type cls;
      logic [34:0]   num;
   } taper_setup_type;

   localparam logic [3:0] K_LAST = 4'(EXP_TABLE_BITS - 1);

   state_type     state_ff, state_in;
   entry_type     ent_ff, ent_in;
   logic [63:0]   mul_ff, mul_in;
   logic [64:0]   rad_ff, rad_in;
   logic [63:0]   root_ff, root_in;
   logic [63:0]   bit_ff, bit_in;
   logic [31:0]   r_ff, r_in;
   logic [30:0]   m_ff, m_in;
   logic [EXP_TABLE_BITS-1:0] frac_ff, frac_in;
   logic [3:0]    k_ff, k_in;
   logic [17:0]   e_ff, e_in;
   taper_cls_type cls_mk_ff, cls_mk_in, cls_rm_ff, cls_rm_in;
   logic [34:0]   rem_mk_ff, rem_mk_in, rem_rm_ff, rem_rm_in;
   logic [16:0]   q_mk_ff, q_mk_in, q_rm_ff, q_rm_in;
   logic [4:0]    div_cnt_ff, div_cnt_in;
   logic          edge_ff, edge_in;
   logic [16:0]   mk_ff, mk_in, rmk_ff, rmk_in;
   logic [35:0]   e2_ff, e2_in;
   logic [17:0]   eos_ff, eos_in;
   logic [36:0]   p_ff, p_in;
   logic [35:0]   eos2_ff, eos2_in;
   logic [41:0]   p16sq_ff, p16sq_in;
   logic [62:0]   sum_ff [NUM_SUMS];
   logic [62:0]   sum_in [NUM_SUMS];
   logic [16:0]   cnt_ff, cnt_in;
   logic [3:0]    idx_ff, idx_in;

   logic          ov_ff, ov_in;
   logic          okind_ff, okind_in;
   logic [17:0]   oe_ff, oe_in;
   logic [31:0]   or_ff, or_in;
   logic [16:0]   omk_ff, omk_in, ormk_ff, ormk_in;
   logic [3:0]    oidx_ff, oidx_in;
   logic [62:0]   oval_ff, oval_in;
   logic          olast_ff, olast_in;

   logic            out_free;
   logic [63:0]     trial;
   logic [61:0]     mprod;
   logic [61:0]     mround;
   logic [48:0]     ewide;
   logic [34:0]     eos_wide;
   logic [52:0]     p_wide;
   logic [20:0]     p16;
   logic [32:0]     r_diff;
   logic [34:0]     divisor;
   logic [35:0]     step_mk;
   logic [35:0]     step_rm;
   taper_setup_type ts_mk;
   taper_setup_type ts_rm;

   function automatic taper_setup_type tp_setup(input logic [31:0] r,
                                                input logic [31:0] rm,
                                                input logic [31:0] s);
      logic [33:0]     r2;
      logic [33:0]     rm2;
      logic [33:0]     s34;
      logic [33:0]     outer2;
      taper_setup_type t;
      r2     = {1'b0, r, 1'b0};
      rm2    = {1'b0, rm, 1'b0};
      s34    = {2'b00, s};
      outer2 = rm2 + s34;
      t.num  = {1'b0, outer2 - r2};
      priority if (r2 > outer2) begin
         t.cls = TP_ZERO;
      end else if (rm2 >= s34 && r2 < rm2 - s34) begin
         t.cls = TP_ONE;
      end else if (s == '0) begin
         t.cls = TP_ONE;
      end else begin
         t.cls = TP_DIV;
      end
      return t;
   endfunction

   // one restoring step: quotient bit on top, new remainder below
   function automatic logic [35:0] div_step(input logic [34:0] rem,
                                            input logic        first,
                                            input logic [34:0] dv);
      logic [34:0] cand;
      logic [35:0] res;
      cand = first ? rem : {rem[33:0], 1'b0};
      if (cand >= dv) begin
         res = {1'b1, cand - dv};
      end else begin
         res = {1'b0, cand};
      end
      return res;
   endfunction

   function automatic logic [62:0] sat_add(input logic [62:0] a, input logic [62:0] b);
      logic [63:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[63] ? SUM_MAX : s[62:0];
   endfunction

   function automatic logic [16:0] mask_sel(input taper_cls_type c, input logic [16:0] q);
      logic [16:0] v;
      unique case (c)
         TP_ONE:  v = ONE_Q16;
         TP_DIV:  v = q;
         default: v = '0;
      endcase
      return v;
   endfunction

   assign out_free = !ov_ff || !rsp_stall;

   always_comb begin
      trial    = root_ff + bit_ff;
      mprod    = 62'(m_ff) * 62'(pow2_frac(k_ff));
      mround   = mprod + (62'd1 << 29);
      ewide    = (49'(m_ff) << ent_ff.exp_int) + (49'd1 << 29);
      eos_wide = 35'(mk_ff) * 35'(e_ff);
      p_wide   = 53'(mk_ff) * 53'(e2_ff);
      p16      = p_ff[36:16];
      r_diff   = (r_ff > sub_radius) ? 33'(r_ff - sub_radius) : 33'(sub_radius - r_ff);
      divisor  = {2'b00, step_size, 1'b0};
      step_mk  = div_step(rem_mk_ff, (div_cnt_ff == '0), divisor);
      step_rm  = div_step(rem_rm_ff, (div_cnt_ff == '0), divisor);
      ts_mk    = tp_setup(r_ff, sub_radius, step_size);
      ts_rm    = tp_setup(r_ff, red_radius, step_size);

      state_in   = state_ff;
      ent_in     = ent_ff;
      mul_in     = mul_ff;
      rad_in     = rad_ff;
      root_in    = root_ff;
      bit_in     = bit_ff;
      r_in       = r_ff;
      m_in       = m_ff;
      frac_in    = frac_ff;
      k_in       = k_ff;
      e_in       = e_ff;
      cls_mk_in  = cls_mk_ff;
      cls_rm_in  = cls_rm_ff;
      rem_mk_in  = rem_mk_ff;
      rem_rm_in  = rem_rm_ff;
      q_mk_in    = q_mk_ff;
      q_rm_in    = q_rm_ff;
      div_cnt_in = div_cnt_ff;
      edge_in    = edge_ff;
      mk_in      = mk_ff;
      rmk_in     = rmk_ff;
      e2_in      = e2_ff;
      eos_in     = eos_ff;
      p_in       = p_ff;
      eos2_in    = eos2_ff;
      p16sq_in   = p16sq_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      q_pop      = 1'b0;

      ov_in    = ov_ff && rsp_stall;
      okind_in = okind_ff;
      oe_in    = oe_ff;
      or_in    = or_ff;
      omk_in   = omk_ff;
      ormk_in  = ormk_ff;
      oidx_in  = oidx_ff;
      oval_in  = oval_ff;
      olast_in = olast_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               ent_in   = q_entry;
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            mul_in   = 64'(ent_ff.ax) * 64'(ent_ff.ay & '0 | ent_ff.ax);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            rad_in   = {1'b0, mul_ff};
            mul_in   = 64'(ent_ff.ay) * 64'(ent_ff.ay);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            rad_in   = rad_ff + {1'b0, mul_ff};
            root_in  = '0;
            bit_in   = 64'd1 << 62;
            m_in     = 31'd1 << 30;
            k_in     = '0;
            frac_in  = ent_ff.exp_frac;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (rad_ff[64]) begin
               // sum of squares past 64 bits
               r_in     = '1;
               state_in = ST_EXP;
            end else begin
               if (rad_ff[63:0] >= trial) begin
                  rad_in  = {1'b0, rad_ff[63:0] - trial};
                  root_in = (root_ff >> 1) + bit_ff;
               end else begin
                  root_in = root_ff >> 1;
               end
               bit_in = bit_ff >> 2;
               if (bit_ff[0]) begin
                  r_in     = root_in[31:0];
                  state_in = ST_EXP;
               end
            end
         end
         ST_EXP: begin
            if (ent_ff.cls != EXP_NORM) begin
               state_in = ST_EFIN;
            end else begin
               if (frac_ff[EXP_TABLE_BITS-1]) begin
                  m_in = mround[60:30];
               end
               frac_in = frac_ff << 1;
               k_in    = k_ff + 1'b1;
               if (k_ff == K_LAST) begin
                  state_in = ST_EFIN;
               end
            end
         end
         ST_EFIN: begin
            unique case (ent_ff.cls)
               EXP_SAT:  e_in = E_MAX;
               EXP_NORM: e_in = (ewide[48:30] > 19'(E_MAX)) ? E_MAX : ewide[47:30];
               default:  e_in = '0;
            endcase
            state_in = ST_TSET;
         end
         ST_TSET: begin
            cls_mk_in  = ts_mk.cls;
            cls_rm_in  = ts_rm.cls;
            rem_mk_in  = ts_mk.num;
            rem_rm_in  = ts_rm.num;
            q_mk_in    = '0;
            q_rm_in    = '0;
            div_cnt_in = '0;
            edge_in    = (r_diff < 33'(step_size));
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            q_mk_in    = {q_mk_ff[15:0], step_mk[35]};
            q_rm_in    = {q_rm_ff[15:0], step_rm[35]};
            rem_mk_in  = step_mk[34:0];
            rem_rm_in  = step_rm[34:0];
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == 5'd16) begin
               state_in = ST_MSEL;
            end
         end
         ST_MSEL: begin
            mk_in    = mask_sel(cls_mk_ff, q_mk_ff);
            rmk_in   = mask_sel(cls_rm_ff, q_rm_ff);
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            e2_in    = 36'(e_ff) * 36'(e_ff);
            eos_in   = eos_wide[33:16];
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            p_in     = p_wide[52:16];
            eos2_in  = 36'(eos_ff) * 36'(eos_ff);
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            p16sq_in = 42'(p16) * 42'(p16);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sum_in[0] = sat_add(sum_ff[0], 63'(mk_ff));
            sum_in[1] = sat_add(sum_ff[1], 63'(e_ff));
            sum_in[2] = sat_add(sum_ff[2], 63'(e2_ff));
            sum_in[3] = sat_add(sum_ff[3], 63'(eos_ff));
            sum_in[4] = sat_add(sum_ff[4], 63'(eos2_ff));
            sum_in[5] = sat_add(sum_ff[5], 63'(p_ff));
            sum_in[6] = sat_add(sum_ff[6], 63'(p16sq_ff));
            if (edge_ff) begin
               sum_in[7] = sat_add(sum_ff[7], 63'(e_ff));
               if (cnt_ff < EDGE_CAP) begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            state_in = ST_EMPT;
         end
         ST_EMPT: begin
            if (out_free) begin
               ov_in    = 1'b1;
               okind_in = 1'b0;
               oe_in    = e_ff;
               or_in    = r_ff;
               omk_in   = mk_ff;
               ormk_in  = rmk_ff;
               oidx_in  = '0;
               oval_in  = '0;
               olast_in = !ent_ff.eos;
               idx_in   = '0;
               state_in = ent_ff.eos ? ST_STAT : ST_IDLE;
            end
         end
         ST_STAT: begin
            if (out_free) begin
               ov_in    = 1'b1;
               okind_in = 1'b1;
               oe_in    = '0;
               or_in    = '0;
               omk_in   = '0;
               ormk_in  = '0;
               oidx_in  = idx_ff;
               oval_in  = (idx_ff == STAT_LAST) ? 63'(cnt_ff) : sum_ff[idx_ff[2:0]];
               olast_in = (idx_ff == STAT_LAST);
               idx_in   = idx_ff + 1'b1;
               if (idx_ff == STAT_LAST) begin
                  for (int i = 0; i < NUM_SUMS; i++) begin
                     sum_in[i] = '0;
                  end
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff    <= ent_in;
      mul_ff    <= mul_in;
      rad_ff    <= rad_in;
      root_ff   <= root_in;
      bit_ff    <= bit_in;
      r_ff      <= r_in;
      m_ff      <= m_in;
      frac_ff   <= frac_in;
      k_ff      <= k_in;
      e_ff      <= e_in;
      cls_mk_ff <= cls_mk_in;
      cls_rm_ff <= cls_rm_in;
      rem_mk_ff <= rem_mk_in;
      rem_rm_ff <= rem_rm_in;
      q_mk_ff   <= q_mk_in;
      q_rm_ff   <= q_rm_in;
      edge_ff   <= edge_in;
      mk_ff     <= mk_in;
      rmk_ff    <= rmk_in;
      e2_ff     <= e2_in;
      eos_ff    <= eos_in;
      p_ff      <= p_in;
      eos2_ff   <= eos2_in;
      p16sq_ff  <= p16sq_in;
      okind_ff  <= okind_in;
      oe_ff     <= oe_in;
      or_ff     <= or_in;
      omk_ff    <= omk_in;
      ormk_ff   <= ormk_in;
      oidx_ff   <= oidx_in;
      oval_ff   <= oval_in;
      olast_ff  <= olast_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
         idx_ff     <= '0;
         cnt_ff     <= '0;
         ov_ff      <= 1'b0;
         for (int i = 0; i < NUM_SUMS; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
         idx_ff     <= idx_in;
         cnt_ff     <= cnt_in;
         ov_ff      <= ov_in;
         sum_ff     <= sum_in;
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_result_kind  = okind_ff;
   assign rsp_e_field      = oe_ff;
   assign rsp_radius       = or_ff;
   assign rsp_mask         = omk_ff;
   assign rsp_reduced_mask = ormk_ff;
   assign rsp_stat_index   = oidx_ff;
   assign rsp_stat_value   = oval_ff;
   assign rsp_last         = olast_ff;

endmodule

### sim/tb_beam_mask_power_accumulator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_beam_mask_power_accumulator_core
// Drives random and directed points with random handshake gaps and register settings, and
// checks each point and scan statistic against a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_beam_mask_power_accumulator_core;
   import bmpa_pkg::*;

   localparam int  LIMIT_CYCLES = 1000000;
   localparam int  SETTLE_CYCLES = 200;
   localparam logic [63:0] SAT63 = 64'h7FFFFFFFFFFFFFFF;

   typedef struct packed {
      logic        kind;
      logic [17:0] e_field;
      logic [31:0] radius;
      logic [16:0] mask;
      logic [16:0] reduced_mask;
      logic [3:0]  stat_index;
      logic [62:0] stat_value;
      logic        last;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_x_angle = '0;
   logic signed [31:0] req_y_angle = '0;
   logic signed [15:0] req_amp_db = '0;
   logic req_end_of_scan = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_result_kind;
   logic [17:0] rsp_e_field;
   logic [31:0] rsp_radius;
   logic [16:0] rsp_mask;
   logic [16:0] rsp_reduced_mask;
   logic [3:0] rsp_stat_index;
   logic [62:0] rsp_stat_value;
   logic rsp_last;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   beam_mask_power_accumulator_core u_top (.*);

   always #2 clock = ~clock;

   // predictor state
   logic signed [63:0] az_nom, el_nom, peak_amp;
   logic [63:0] sub_rad, red_rad, step;
   logic [63:0] scan_sums[8];
   logic [63:0] edge_count;

   result_type expected_results[$];
   int      error_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_cycles = 0;
   longint  cycle_count = 0;

   localparam logic [63:0] FRAC_Q30[14] = '{
      64'd1518500250, 64'd1276901417, 64'd1170923762, 64'd1121280438,
      64'd1097253708, 64'd1085434106, 64'd1079572136, 64'd1076653033,
      64'd1075196443, 64'd1074468888, 64'd1074105294, 64'd1073923544,
      64'd1073832680, 64'd1073787251};

   function automatic logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > SAT63) ? SAT63 : s;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] db_to_field(logic signed [63:0] d);
      logic signed [63:0] u;
      logic [63:0] n, frac, m, e;
      u = d * 64'sd10885 + (64'sd16 <<< 24);
      if (u >= (64'sd18 <<< 24)) return 64'(E_MAX);
      if (u < 0) return 0;
      n = u >>> 24;
      frac = (u & 64'hFFFFFF) >> (24 - EXP_TABLE_BITS);
      m = 64'd1 << 30;
      for (int k = 0; k < EXP_TABLE_BITS && k < 14; k++)
         if (frac[EXP_TABLE_BITS-1-k])
            m = (m * FRAC_Q30[k] + (64'd1 << 29)) >> 30;
      e = ((m << n) + (64'd1 << 29)) >> 30;
      return (e > 64'(E_MAX)) ? 64'(E_MAX) : e;
   endfunction

   function automatic logic [63:0] mask_weight(logic [63:0] r, logic [63:0] rm,
                                                logic [63:0] s);
      logic [63:0] r2, outer2;
      r2 = r << 1;
      outer2 = (rm << 1) + s;
      if (r2 > outer2) return 0;
      if ((rm << 1) >= s && r2 < (rm << 1) - s) return 64'(ONE_Q16);
      if (s == 0) return 64'(ONE_Q16);
      return ((outer2 - r2) << 16) / (s << 1);
   endfunction

   task automatic predict_point(logic signed [31:0] x, logic signed [31:0] y,
                                logic signed [15:0] amp, logic eos);
      logic signed [63:0] dx, dy;
      logic [63:0] ax, ay, sx, sy, r, e, mk, rmk, e2, eo, p, p16, diff;
      logic [63:0] edge_cap;
      result_type res;
      edge_cap = 64'(EDGE_CAP_INT);
      dx = 64'(x) - az_nom;
      dy = 64'(y) - el_nom;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      sx = ax * ax;
      sy = ay * ay;
      e = db_to_field(64'(amp) - peak_amp);
      if (sx > ~sy) r = 64'hFFFFFFFF;
      else r = int_sqrt(sx + sy);
      if (r > 64'hFFFFFFFF) r = 64'hFFFFFFFF;
      mk = mask_weight(r, sub_rad, step);
      rmk = mask_weight(r, red_rad, step);
      e2 = e * e;
      eo = (mk * e) >> 16;
      p = (mk * e2) >> 16;
      p16 = p >> 16;
      scan_sums[0] = sum_sat(scan_sums[0], mk);
      scan_sums[1] = sum_sat(scan_sums[1], e);
      scan_sums[2] = sum_sat(scan_sums[2], e2);
      scan_sums[3] = sum_sat(scan_sums[3], eo);
      scan_sums[4] = sum_sat(scan_sums[4], eo * eo);
      scan_sums[5] = sum_sat(scan_sums[5], p);
      scan_sums[6] = sum_sat(scan_sums[6], p16 * p16);
      diff = r > sub_rad ? r - sub_rad : sub_rad - r;
      if (diff < step) begin
         scan_sums[7] = sum_sat(scan_sums[7], e);
         if (edge_count < edge_cap) edge_count++;
      end
      res = '0;
      res.e_field = e[17:0];
      res.radius = r[31:0];
      res.mask = mk[16:0];
      res.reduced_mask = rmk[16:0];
      res.last = !eos;
      expected_results.insert(expected_results.size(), res);
      if (eos) begin
         for (int i = 0; i < NUM_STATS; i++) begin
            res = '0;
            res.kind = 1'b1;
            res.stat_index = 4'(i);
            res.stat_value = (i < NUM_SUMS) ? scan_sums[i][62:0] : edge_count[62:0];
            res.last = (i == NUM_STATS - 1);
            expected_results.insert(expected_results.size(), res);
         end
         foreach (scan_sums[i]) scan_sums[i] = 0;
         edge_count = 0;
      end
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_AZ_NOMINAL: az_nom = 64'(signed'(val));
         CSR_EL_NOMINAL: el_nom = 64'(signed'(val));
         CSR_SUB_RADIUS: sub_rad = 64'(val);
         CSR_RED_RADIUS: red_rad = 64'(val);
         CSR_STEP_SIZE:  step = 64'(val);
         CSR_COPOL_PEAK: peak_amp = 64'(signed'(val[15:0]));
         default: ;
      endcase
   endtask

   // send one point; valid stays high into the next item, the caller drops it
   task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [15:0] amp, logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_x_angle <= x;
      req_y_angle <= y;
      req_amp_db <= amp;
      req_end_of_scan <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_point(x, y, amp, eos);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one scan of random points, mostly around the pointing within the given spread
   task automatic send_scan(int npts, int spread);
      logic signed [31:0] x, y;
      logic signed [15:0] amp;
      for (int i = 0; i < npts; i++) begin
         if ($urandom_range(9) == 0) begin
            x = $urandom;
            y = $urandom;
            amp = 16'($urandom);
         end else begin
            x = 32'(az_nom) + $signed(32'($urandom_range(2 * spread))) - spread;
            y = 32'(el_nom) + $signed(32'($urandom_range(2 * spread))) - spread;
            amp = 16'(peak_amp) - 16'($urandom_range(40 * 256));
         end
         send_point(x, y, amp, i == npts - 1);
      end
   endtask

   task automatic test_directed();
      write_reg(CSR_SUB_RADIUS, 32'd4 << 16);
      write_reg(CSR_RED_RADIUS, 32'd2 << 16);
      send_point(0, 0, 0, 1'b0);
      send_point(32'd4 << 16, 0, 16'sh7FFF, 1'b0);
      send_point(32'sh80000000, 32'sh80000000, 16'sh8000, 1'b0);
      send_point(32'sh7FFFFFFF, 32'sh80000000, 16'sd512, 1'b0);
      send_point(32'd3 << 16, 32'd1 << 15, -16'sd1, 1'b0);
      send_point(32'd2 << 16, 0, 16'sd1541, 1'b0);
      send_point(32'h7FFFFFFF, 32'h7FFFFFFF, -16'sd25600, 1'b0);
      send_point(32'd1 << 15, 0, -16'sd24660, 1'b1);
      wait_drained();
      // zero step: radius exactly on the mask edge
      write_reg(CSR_STEP_SIZE, 0);
      send_point(32'd4 << 16, 0, 0, 1'b0);
      send_point(32'd2 << 16, 0, 0, 1'b0);
      send_point(32'd5 << 16, 0, 0, 1'b1);
      wait_drained();
      // huge step: taper reaches r = 0
      write_reg(CSR_STEP_SIZE, 32'hFFFFFFFF);
      write_reg(CSR_COPOL_PEAK, 32'h00008000);
      write_reg(CSR_AZ_NOMINAL, 32'h80000000);
      write_reg(CSR_EL_NOMINAL, 32'h7FFFFFFF);
      send_point(32'h7FFFFFFF, 32'h80000000, 16'sh7FFF, 1'b0);
      send_point(32'h80000000, 32'h7FFFFFFF, 16'sh7FFF, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 65 : 0;
         recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 20 : 0;
         for (int s = 0; s < 4; s++) begin
            write_reg(CSR_AZ_NOMINAL, $urandom);
            write_reg(CSR_EL_NOMINAL, $urandom);
            write_reg(CSR_SUB_RADIUS, $urandom_range(1 << 20));
            write_reg(CSR_RED_RADIUS, $urandom_range(1 << 19));
            write_reg(CSR_STEP_SIZE, (s == 0) ? 32'd1 : $urandom_range(1 << 18));
            write_reg(CSR_COPOL_PEAK, $urandom);
            send_scan($urandom_range(20, 28), 1 << 20);
            wait_drained();
         end
      end
   endtask

   task automatic test_backpressure();
      write_reg(CSR_SUB_RADIUS, 32'hFFFFFFFF);
      write_reg(CSR_RED_RADIUS, 32'hFFFFFFFF);
      write_reg(CSR_STEP_SIZE, 32'd65536);
      hold_cycles = 3000;
      send_scan(10, 1 << 22);
      wait_drained();
   endtask

   // receiver stall and result check
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      result_type got, want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_result_kind, rsp_e_field, rsp_radius, rsp_mask,
                 rsp_reduced_mask, rsp_stat_index, rsp_stat_value, rsp_last};
         if (expected_results.size() == 0) begin
            $error("unexpected result item kind=%0d", got.kind);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (got.kind != want.kind) begin
               $error("result_kind exp %0d got %0d", want.kind, got.kind); error_count++; end
            if (got.e_field != want.e_field) begin
               $error("e_field exp %0d got %0d", want.e_field, got.e_field); error_count++; end
            if (got.radius != want.radius) begin
               $error("radius exp %0d got %0d", want.radius, got.radius); error_count++; end
            if (got.mask != want.mask) begin
               $error("mask exp %0d got %0d", want.mask, got.mask); error_count++; end
            if (got.reduced_mask != want.reduced_mask) begin
               $error("reduced_mask exp %0d got %0d", want.reduced_mask, got.reduced_mask);
               error_count++;
            end
            if (got.stat_index != want.stat_index) begin
               $error("stat_index exp %0d got %0d", want.stat_index, got.stat_index);
               error_count++;
            end
            if (got.stat_value != want.stat_value) begin
               $error("stat_value exp %0d got %0d", want.stat_value, got.stat_value);
               error_count++;
            end
            if (got.last != want.last) begin
               $error("last exp %0d got %0d", want.last, got.last); error_count++; end
         end
      end
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb_beam_mask_power_accumulator_core: FAIL");
         $finish;
      end
   end

   initial begin
      az_nom = 0; el_nom = 0; sub_rad = 0; red_rad = 0;
      step = 65536; peak_amp = 0; edge_count = 0;
      foreach (scan_sums[i]) scan_sums[i] = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_settings();
      test_backpressure();
      wait_drained();
      if (error_count == 0) begin
         $display("tb_beam_mask_power_accumulator_core: PASS");
      end else begin
         $display("tb_beam_mask_power_accumulator_core: FAIL");
      end
      $finish;
   end

endmodule

### files.f
sv/bmpa_pkg.sv
sv/bmpa_front.sv
sv/bmpa_queue.sv
sv/bmpa_back.sv
sv/beam_mask_power_accumulator_core.sv
sim/tb_beam_mask_power_accumulator_core.sv
